// ===== rtl/core/gpfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpfd_pkg
// Shared types for the gamepad pair frame decoder: event kinds and the
// decoded event record passed from the scan logic to the result register.
// ----------------------------------------------------------------------------
package gpfd_pkg;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_AXIS  = 2'd1,
        KIND_STICK = 2'd2
    } event_kind_t;

    typedef struct packed {
        event_kind_t        kind;
        logic [3:0]         index;
        logic               pressed;
        logic signed [15:0] value;
    } event_t;

    // result of one scan over the held bytes plus the new byte
    typedef struct packed {
        logic       got;
        event_t     ev;
        logic [1:0] held_count;
        logic [7:0] held0;
        logic [7:0] held1;
        logic [7:0] dir;
    } scan_result_t;

    localparam logic [7:0] PREFIX_BYTE = 8'hFF;

endpackage

// ===== rtl/core/gamepad_pair_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_pair_frame_decoder
// Byte-stream decoder for two-byte key and axis frames and three-byte
// stick frames, producing one key, axis or stick event per decoded frame.
// ----------------------------------------------------------------------------
// One byte is taken every cycle while in_stall is low. A byte goes into the
// input register, the scan over the held bytes and that byte is settled in the
// following cycle, and its event (if any) is loaded into the result register
// as soon as that register is free. The combinational scan of the three-byte
// window sets this rate; input stalls only while the result register is still
// held and the byte in the input register yields an event.
// Write second_mode only while the block is idle; held bytes and direction
// bits are kept across a mode change.
module gamepad_pair_frame_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          byte_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          event_kind,
    output logic [3:0]          control_index,
    output logic                key_pressed,
    output logic signed [15:0]  axis_value
);
    import gpfd_pkg::*;

    logic         mode_reg;
    logic         s1_valid_reg;
    logic [7:0]   s1_byte_reg;
    logic [1:0]   held_count_reg;
    logic [7:0]   held0_reg;
    logic [7:0]   held1_reg;
    logic [7:0]   dir_reg;
    logic         out_valid_reg;
    event_t       out_ev_reg;

    scan_result_t scan;
    logic         out_free;
    logic         dec_fire;

    gpfd_scan u_scan (
        .mode       (mode_reg),
        .held_count (held_count_reg),
        .held0      (held0_reg),
        .held1      (held1_reg),
        .dir_in     (dir_reg),
        .byte_in    (s1_byte_reg),
        .result     (scan)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign dec_fire = s1_valid_reg && (!scan.got || out_free);
    assign in_stall = s1_valid_reg && !dec_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            s1_valid_reg   <= 1'b0;
            held_count_reg <= '0;
            dir_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                mode_reg <= cfg_data;
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (dec_fire)
            begin
                held_count_reg <= scan.held_count;
                dir_reg        <= scan.dir;
            end
            if (dec_fire && scan.got)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_byte_reg <= byte_in;
        if (dec_fire)
        begin
            held0_reg <= scan.held0;
            held1_reg <= scan.held1;
        end
        if (dec_fire && scan.got)
            out_ev_reg <= scan.ev;
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_ev_reg.kind;
    assign control_index = out_ev_reg.index;
    assign key_pressed   = out_ev_reg.pressed;
    assign axis_value    = out_ev_reg.value;

    // two bytes wait only as the head of a stick frame
    a_held_pair_is_stick_head: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg == 2'd2 |-> held0_reg == PREFIX_BYTE
            && (held1_reg == 8'h11 || held1_reg == 8'h12
                || held1_reg == 8'h13 || held1_reg == 8'h14))
        else $error("held pair is not a stick frame head");

    a_held_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("held count out of range");

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with a free result register");

    a_key_has_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == KIND_KEY |-> axis_value == 16'sd0)
        else $error("key event carries an axis value");

    a_stick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == KIND_STICK
            |-> axis_value <= 16'sd127 && axis_value >= -16'sd127 && !key_pressed)
        else $error("stick position out of range");

endmodule

// ===== rtl/core/gpfd_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpfd_scan
// Combinational frame scan over the held bytes and the newest byte: settles
// key pairs, axis pairs and stick frames, drops bad bytes and returns the
// bytes left waiting together with the updated direction bits.
// ----------------------------------------------------------------------------
module gpfd_scan (
    input  logic                    mode,
    input  logic [1:0]              held_count,
    input  logic [7:0]              held0,
    input  logic [7:0]              held1,
    input  logic [7:0]              dir_in,
    input  logic [7:0]              byte_in,
    output gpfd_pkg::scan_result_t  result
);
    import gpfd_pkg::*;

    localparam logic [3:0] AX_LX = 4'd0;
    localparam logic [3:0] AX_LY = 4'd1;
    localparam logic [3:0] AX_RX = 4'd2;
    localparam logic [3:0] AX_RY = 4'd3;
    localparam logic [3:0] AX_L2 = 4'd4;
    localparam logic [3:0] AX_R2 = 4'd5;

    localparam logic signed [15:0] FULL_POS = 16'sd32767;
    localparam logic signed [15:0] FULL_NEG = -16'sd32768;

    typedef struct packed {
        logic       ok;
        event_t     ev;
        logic [7:0] dir;
    } pair_t;

    // stick axes and direction pairs share the same order
    function automatic logic [3:0] axis_of(input logic [1:0] sel);
        logic [3:0] ax;
        case (sel)
            2'd0:    ax = AX_LY;
            2'd1:    ax = AX_LX;
            2'd2:    ax = AX_RY;
            default: ax = AX_RX;
        endcase
        return ax;
    endfunction

    function automatic logic signed [15:0] stick_pos(input logic [7:0] v);
        logic signed [15:0] p;
        if (v == 8'hFF)
            p = 16'sd127;
        else
            p = $signed({8'd0, v}) - 16'sd127;
        return p;
    endfunction

    function automatic pair_t first_pair(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] dir);
        pair_t r;
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        r = '0;
        r.dir = dir;
        r.ev.kind = KIND_KEY;
        r.ev.index = a[3:0];
        r.ev.pressed = (a[7:4] == 4'hB);
        r.ok = (sum == 9'h0FF) && a[7] && !b[7]
            && (a[7:4] == 4'hB || a[7:4] == 4'hF)
            && (a[3:0] >= 4'h4) && (a[3:0] <= 4'hE);
        return r;
    endfunction

    function automatic pair_t second_pair(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] dir);
        pair_t r;
        logic [3:0] n;
        logic [2:0] idx;
        logic [2:0] neg_bit;
        logic       pressed;
        logic       neg;
        logic       posv;
        logic [7:0] d;
        n = a[3:0];
        idx = 3'(n - 4'd1);
        neg_bit = {idx[2:1], 1'b0};
        pressed = (a[7:4] == 4'hB) || (a[7:4] == 4'hA);
        r = '0;
        r.dir = dir;
        d = dir;
        if (a[7:4] == 4'hB || a[7:4] == 4'hF) begin
            if (n >= 4'h3 && n <= 4'hE) begin
                r.ok = (b == ~a);
                r.ev.kind = KIND_KEY;
                r.ev.index = n;
                r.ev.pressed = pressed;
            end else if (n == 4'h1 || n == 4'h2) begin
                if (n == 4'h1)
                    r.ok = (b == (pressed ? 8'h4D : 8'h0D));
                else
                    r.ok = (b == (pressed ? 8'h4E : 8'h0E));
                r.ev.kind = KIND_AXIS;
                r.ev.index = (n == 4'h1) ? AX_L2 : AX_R2;
                r.ev.value = pressed ? FULL_POS : FULL_NEG;
            end
        end else if (a[7:4] == 4'hA || a[7:4] == 4'hE) begin
            r.ok = (n >= 4'h1) && (n <= 4'h8)
                && (b == ((pressed ? 8'h20 : 8'h10) + {4'd0, n}));
            d[idx] = pressed;
            neg = d[neg_bit];
            posv = d[neg_bit + 3'd1];
            r.ev.kind = KIND_AXIS;
            r.ev.index = axis_of(idx[2:1]);
            r.ev.value = (neg && !posv) ? FULL_NEG : (posv && !neg) ? FULL_POS : 16'sd0;
            if (r.ok)
                r.dir = d;
        end
        return r;
    endfunction

    logic [7:0] win [0:3];
    logic [1:0] len;
    logic [1:0] pos;
    logic [1:0] left;
    logic [1:0] rem;
    logic       stop;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    pair_t      pr;

    always_comb
    begin
        win[0] = byte_in;
        win[1] = '0;
        win[2] = '0;
        win[3] = '0;
        len = 2'd1;
        case (held_count)
            2'd0: ;
            2'd1:
            begin
                win[0] = held0;
                win[1] = byte_in;
                len = 2'd2;
            end
            default:
            begin
                win[0] = held0;
                win[1] = held1;
                win[2] = byte_in;
                len = 2'd3;
            end
        endcase

        pos = '0;
        stop = 1'b0;
        left = '0;
        a = '0;
        b = '0;
        c = '0;
        pr = '0;
        result = '0;
        result.dir = dir_in;

        // every pass consumes at least one byte, so three passes cover the window
        for (int it = 0; it < 3; it++)
        begin
            if (!stop && pos < len)
            begin
                left = len - pos;
                a = win[pos];
                b = win[pos + 2'd1];
                c = win[pos + 2'd2];
                if (mode && a == PREFIX_BYTE)
                begin
                    if (left < 2'd2)
                        stop = 1'b1;
                    else if (b >= 8'h11 && b <= 8'h14)
                    begin
                        if (left < 2'd3)
                            stop = 1'b1;
                        else
                        begin
                            if (!result.got)
                            begin
                                result.got = 1'b1;
                                result.ev.kind = KIND_STICK;
                                result.ev.index = axis_of(b[1:0] - 2'd1);
                                result.ev.pressed = 1'b0;
                                result.ev.value = stick_pos(c);
                            end
                            pos = pos + 2'd3;
                        end
                    end
                    else
                        pos = pos + 2'd1;
                end
                else if (left < 2'd2)
                    stop = 1'b1;
                else
                begin
                    pr = mode ? second_pair(a, b, result.dir) : first_pair(a, b, result.dir);
                    // once an event is out, later pairs only cost a byte
                    if (!result.got && pr.ok)
                    begin
                        result.got = 1'b1;
                        result.ev = pr.ev;
                        result.dir = pr.dir;
                        pos = pos + 2'd2;
                    end
                    else
                        pos = pos + 2'd1;
                end
            end
        end

        rem = len - pos;
        result.held_count = (rem == 2'd3) ? 2'd2 : rem;
        result.held0 = win[pos];
        result.held1 = win[pos + 2'd1];
    end

endmodule

// ===== tb/sv/tb_gamepad_pair_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gamepad_pair_frame_decoder
// Byte-stream testbench for the pad pair frame decoder. A queue of stream
// bytes feeds a valid/stall driver. Every accepted byte runs through an
// in-bench decoder that predicts the event it yields. A monitor compares each
// accepted event field by field against the oldest prediction. Both sides
// idle at random. Both protocol modes are exercised, starting with directed
// frames and then random well-formed frames mixed with broken frames and noise.
// ----------------------------------------------------------------------------
module tb_gamepad_pair_frame_decoder;

    import gpfd_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;

    // frame codes
    localparam logic [3:0] NIB_PRESS       = 4'hB;
    localparam logic [3:0] NIB_RELEASE     = 4'hF;
    localparam logic [3:0] NIB_DIR_PRESS   = 4'hA;
    localparam logic [3:0] NIB_DIR_RELEASE = 4'hE;
    localparam logic [3:0] KEY_LOW_FIRST   = 4'd4;
    localparam logic [3:0] KEY_LOW_SECOND  = 4'd3;
    localparam logic [3:0] KEY_HIGH        = 4'd14;
    localparam logic [3:0] TRIG_L2         = 4'd1;
    localparam logic [3:0] TRIG_R2         = 4'd2;
    localparam logic [7:0] L2_DOWN         = 8'h4D;
    localparam logic [7:0] L2_UP           = 8'h0D;
    localparam logic [7:0] R2_DOWN         = 8'h4E;
    localparam logic [7:0] R2_UP           = 8'h0E;
    localparam logic [7:0] DIR_DOWN_BASE   = 8'h20;
    localparam logic [7:0] DIR_UP_BASE     = 8'h10;
    localparam logic [7:0] STICK_FIRST     = 8'h11;
    localparam logic [7:0] STICK_LAST      = 8'h14;

    localparam logic [3:0] AXIS_L2 = 4'd4;
    localparam logic [3:0] AXIS_R2 = 4'd5;

    localparam logic signed [15:0] FULL_POS = 16'sh7FFF;
    localparam logic signed [15:0] FULL_NEG = 16'sh8000;
    localparam int STICK_CENTER = 127;
    localparam int STICK_CAP    = 127;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_data = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         byte_in = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         event_kind;
    logic [3:0]         control_index;
    logic               key_pressed;
    logic signed [15:0] axis_value;

    logic [7:0]  stream_bytes [$];
    event_t      expected_events [$];
    int unsigned idle_pct = 15;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;

    // decoder state mirrored by the bench
    bit          mode_q = 1'b0;
    logic [7:0]  held_q [2];
    int unsigned held_count = 0;
    logic [7:0]  dir_bits = 8'h00;

    gamepad_pair_frame_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_in       (byte_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .control_index (control_index),
        .key_pressed   (key_pressed),
        .axis_value    (axis_value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // stick pairs and direction pairs share one order: ly, lx, ry, rx
    function automatic logic [3:0] axis_of_pair(input logic [1:0] p);
        return {2'b00, p[1], ~p[0]};
    endfunction

    function automatic bit first_mode_pair(input logic [7:0] a, input logic [7:0] b,
                                           output event_t ev);
        ev = '0;
        if ({1'b0, a} + {1'b0, b} != 9'h0FF || !a[7] || b[7])
            return 1'b0;
        if ((a[7:4] != NIB_PRESS && a[7:4] != NIB_RELEASE)
            || a[3:0] < KEY_LOW_FIRST || a[3:0] > KEY_HIGH)
            return 1'b0;
        ev.kind = KIND_KEY;
        ev.index = a[3:0];
        ev.pressed = (a[7:4] == NIB_PRESS);
        return 1'b1;
    endfunction

    function automatic bit second_mode_pair(input logic [7:0] a, input logic [7:0] b,
                                            output event_t ev);
        logic [3:0] n;
        logic [2:0] idx;
        logic [7:0] want;
        logic       down;
        logic       neg_held;
        logic       pos_held;
        n = a[3:0];
        ev = '0;
        if (a[7:4] == NIB_PRESS || a[7:4] == NIB_RELEASE)
        begin
            down = (a[7:4] == NIB_PRESS);
            if (n >= KEY_LOW_SECOND && n <= KEY_HIGH)
                want = 8'hFF - a;
            else if (n == TRIG_L2)
                want = down ? L2_DOWN : L2_UP;
            else if (n == TRIG_R2)
                want = down ? R2_DOWN : R2_UP;
            else
                return 1'b0;
            if (b != want)
                return 1'b0;
            if (n == TRIG_L2 || n == TRIG_R2)
            begin
                ev.kind = KIND_AXIS;
                ev.index = (n == TRIG_L2) ? AXIS_L2 : AXIS_R2;
                ev.value = down ? FULL_POS : FULL_NEG;
            end
            else
            begin
                ev.kind = KIND_KEY;
                ev.index = n;
                ev.pressed = down;
            end
            return 1'b1;
        end
        if (a[7:4] == NIB_DIR_PRESS || a[7:4] == NIB_DIR_RELEASE)
        begin
            down = (a[7:4] == NIB_DIR_PRESS);
            if (n < 4'd1 || n > 4'd8
                || b != (down ? DIR_DOWN_BASE : DIR_UP_BASE) + {4'h0, n})
                return 1'b0;
            idx = 3'(n - 4'd1);
            dir_bits[idx] = down;
            neg_held = dir_bits[{idx[2:1], 1'b0}];
            pos_held = dir_bits[{idx[2:1], 1'b1}];
            ev.kind = KIND_AXIS;
            ev.index = axis_of_pair(idx[2:1]);
            ev.value = (neg_held && !pos_held) ? FULL_NEG
                     : (pos_held && !neg_held) ? FULL_POS : 16'sd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // rescan held bytes plus the new byte, keep what is left over
    function automatic void decode_byte(input logic [7:0] b);
        logic [7:0]  win [3];
        int unsigned len;
        int unsigned pos;
        int unsigned i;
        int          stick_pos;
        bit          got;
        bit          ok;
        event_t      ev;
        event_t      found;
        got = 1'b0;
        pos = 0;
        found = '0;
        len = held_count;
        for (i = 0; i < len; i++)
            win[i] = held_q[i];
        win[len] = b;
        len++;
        while (pos < len)
        begin
            if (mode_q && win[pos] == PREFIX_BYTE)
            begin
                if (len - pos < 2)
                    break;
                if (win[pos + 1] >= STICK_FIRST && win[pos + 1] <= STICK_LAST)
                begin
                    if (len - pos < 3)
                        break;
                    if (!got)
                    begin
                        stick_pos = int'(win[pos + 2]) - STICK_CENTER;
                        if (stick_pos > STICK_CAP)
                            stick_pos = STICK_CAP;
                        found = '0;
                        found.kind = KIND_STICK;
                        found.index = axis_of_pair(2'(win[pos + 1] - STICK_FIRST));
                        found.value = 16'(stick_pos);
                        got = 1'b1;
                    end
                    pos += 3;
                end
                else
                    pos += 1;
            end
            else
            begin
                if (len - pos < 2)
                    break;
                ok = 1'b0;
                if (!got)
                begin
                    if (mode_q)
                        ok = second_mode_pair(win[pos], win[pos + 1], ev);
                    else
                        ok = first_mode_pair(win[pos], win[pos + 1], ev);
                end
                if (ok)
                begin
                    found = ev;
                    got = 1'b1;
                    pos += 2;
                end
                else
                    pos += 1;
            end
        end
        held_count = 0;
        while (pos < len && held_count < 2)
        begin
            held_q[held_count] = win[pos];
            held_count++;
            pos++;
        end
        if (got)
            expected_events.push_back(found);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                decode_byte(byte_in);
            if (!in_valid || !in_stall)
            begin
                if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    byte_in <= stream_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        event_t exp_ev;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected event: kind %0d index %0d pressed %0d value %0d",
                           event_kind, control_index, key_pressed, axis_value);
                    mismatches++;
                end
                else
                begin
                    exp_ev = expected_events.pop_front();
                    if (event_kind !== exp_ev.kind)
                    begin
                        $error("event_kind: expected %0d, got %0d", exp_ev.kind, event_kind);
                        mismatches++;
                    end
                    if (control_index !== exp_ev.index)
                    begin
                        $error("control_index: expected %0d, got %0d",
                               exp_ev.index, control_index);
                        mismatches++;
                    end
                    if (key_pressed !== exp_ev.pressed)
                    begin
                        $error("key_pressed: expected %0d, got %0d",
                               exp_ev.pressed, key_pressed);
                        mismatches++;
                    end
                    if (axis_value !== exp_ev.value)
                    begin
                        $error("axis_value: expected %0d, got %0d", exp_ev.value, axis_value);
                        mismatches++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // wait until the stream is drained and the pipeline is empty
    task automatic settle();
        do
            @(negedge clk);
        while (stream_bytes.size() != 0 || in_valid || expected_events.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(input bit value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        mode_q = value;
        @(negedge clk);
    endtask

    task automatic push_key(input bit down, input logic [3:0] key);
        logic [7:0] a;
        a = {down ? NIB_PRESS : NIB_RELEASE, key};
        stream_bytes.push_back(a);
        stream_bytes.push_back(8'hFF - a);
    endtask

    // mostly well-formed frames with random content, the rest broken or noise
    task automatic queue_random(input bit mode, input int unsigned n_bytes);
        int unsigned start;
        int unsigned r;
        logic [3:0]  n;
        bit          down;
        logic [7:0]  a;
        start = stream_bytes.size();
        while (stream_bytes.size() - start < n_bytes)
        begin
            r = $urandom_range(0, 99);
            down = 1'($urandom_range(0, 1));
            if (!mode)
            begin
                n = 4'($urandom_range(KEY_LOW_FIRST, KEY_HIGH));
                if (r < 60)
                    push_key(down, n);
                else if (r < 75)
                begin
                    stream_bytes.push_back({down ? NIB_PRESS : NIB_RELEASE, n});
                    stream_bytes.push_back(8'($urandom_range(0, 255)));
                end
                else
                    stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if (r < 30)
                push_key(down, 4'($urandom_range(KEY_LOW_SECOND, KEY_HIGH)));
            else if (r < 40)
            begin
                n = $urandom_range(0, 1) ? TRIG_L2 : TRIG_R2;
                stream_bytes.push_back({down ? NIB_PRESS : NIB_RELEASE, n});
                if (n == TRIG_L2)
                    stream_bytes.push_back(down ? L2_DOWN : L2_UP);
                else
                    stream_bytes.push_back(down ? R2_DOWN : R2_UP);
            end
            else if (r < 65)
            begin
                n = 4'($urandom_range(1, 8));
                stream_bytes.push_back({down ? NIB_DIR_PRESS : NIB_DIR_RELEASE, n});
                stream_bytes.push_back((down ? DIR_DOWN_BASE : DIR_UP_BASE) + {4'h0, n});
            end
            else if (r < 80)
            begin
                stream_bytes.push_back(PREFIX_BYTE);
                stream_bytes.push_back(8'($urandom_range(STICK_FIRST, STICK_LAST)));
                stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if (r < 90)
            begin
                case ($urandom_range(0, 2))
                    0: a = PREFIX_BYTE;
                    1: a = {down ? NIB_DIR_PRESS : NIB_DIR_RELEASE, 4'($urandom_range(0, 15))};
                    default: a = {down ? NIB_PRESS : NIB_RELEASE, 4'($urandom_range(0, 15))};
                endcase
                stream_bytes.push_back(a);
                stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
                stream_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_mode(1'b0);

        // first mode: press, release, key F rejected, key 3 rejected, extremes
        push_key(1'b1, 4'h4);
        push_key(1'b0, 4'hE);
        push_key(1'b1, 4'hF);
        push_key(1'b1, 4'h3);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'h00);
        settle();

        // second mode: key 3, triggers, opposing directions, sticks, bad prefix
        write_mode(1'b1);
        push_key(1'b1, 4'h3);
        stream_bytes.push_back(8'hB1);
        stream_bytes.push_back(L2_DOWN);
        stream_bytes.push_back(8'hF2);
        stream_bytes.push_back(R2_UP);
        stream_bytes.push_back(8'hA1);
        stream_bytes.push_back(8'h21);
        stream_bytes.push_back(8'hA2);
        stream_bytes.push_back(8'h22);
        stream_bytes.push_back(8'hE1);
        stream_bytes.push_back(8'h11);
        stream_bytes.push_back(PREFIX_BYTE);
        stream_bytes.push_back(STICK_FIRST);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(PREFIX_BYTE);
        stream_bytes.push_back(STICK_LAST);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(PREFIX_BYTE);
        stream_bytes.push_back(8'h20);
        // lone prefix left held across the mode change
        stream_bytes.push_back(PREFIX_BYTE);
        settle();

        write_mode(1'b0);
        queue_random(1'b0, 200);
        settle();

        // long stretch without idling on either side
        write_mode(1'b1);
        idle_pct = 0;
        queue_random(1'b1, 150);
        settle();
        idle_pct = 15;
        queue_random(1'b1, 150);
        settle();

        write_mode(1'b0);
        queue_random(1'b0, 100);
        settle();

        write_mode(1'b1);
        queue_random(1'b1, 250);
        settle();
        repeat (8) @(negedge clk);

        if (mismatches == 0 && expected_events.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
